// ===== design/mows_pkg.sv =====
// Package for the windowed median filter: sample width, default window, cell link type.
`default_nettype none

package mows_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int WINDOW_DEF = 21;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // What one sorter cell hands to its right-hand neighbor.
  typedef struct packed {
    logic    stay;   // cell keeps its value on this insertion
    sample_t value;  // value held by the cell
  } link_t;

endpackage : mows_pkg

`default_nettype wire

// ===== design/median_of_window_samples.sv =====
// Top level of the batch median filter: sorter cell chain, batch counter, result register.
`default_nettype none

// Batch median filter. Samples arrive on the in_ channel one transfer at a
// time; every WINDOW samples form a batch, and the transfer that completes a
// batch produces one result on the out_ channel: the value at sorted index
// (WINDOW-1)/2 of that batch (the median for odd WINDOW, the lower middle
// value for even WINDOW). Batches do not overlap. The block takes one sample
// per cycle while in_stall is low: a row of WINDOW cells keeps the current
// batch in ascending order, and each sample is inserted at once by all cells
// comparing against it in parallel and shifting right past the insertion
// point. The median is picked from the chain's next-state on the last sample,
// so the result is valid in the cycle after that transfer, and the next batch
// can start in that same cycle. in_stall is high only while the next sample
// would complete a batch and an earlier result still waits, stalled, in the
// output register; it does not look at in_valid.
// No clearing pass is needed after reset.

module median_of_window_samples #(
  parameter int WINDOW = mows_pkg::WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mows_pkg::sample_t in_sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mows_pkg::sample_t      out_median_value
);
  import mows_pkg::*;

  localparam int CNT_W = $clog2(WINDOW);
  localparam int MID   = (WINDOW - 1) / 2;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             out_valid_r, out_valid_nxt;
  sample_t          median_r, median_nxt;

  logic    last;
  logic    in_xfer;
  link_t   link [WINDOW+1];
  sample_t cell_nxt [WINDOW];

  assign last     = (fill_r == CNT_W'(WINDOW - 1));
  // Only a batch-completing sample needs room in the result register.
  assign in_stall = last && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // Head of the chain: behaves like a cell that always stays, so cell 0
  // takes the sample whenever it moves its own value on.
  assign link[0].stay  = 1'b1;
  assign link[0].value = '0;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    mows_cell u_cell (
      .clk       (clk),
      .load      (in_xfer),
      .occupied  (fill_r > CNT_W'(k)),
      .sample    (in_sample),
      .left      (link[k]),
      .right     (link[k+1]),
      .value_nxt (cell_nxt[k])
    );
  end

  // The last cell's outgoing link has no consumer beyond the chain.
  logic unused_tail;
  assign unused_tail = ^link[WINDOW];

  always_comb begin
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    median_nxt    = median_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      if (last) begin
        fill_nxt      = '0;
        out_valid_nxt = 1'b1;
        median_nxt    = cell_nxt[MID];
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    median_r <= median_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = median_r;

endmodule : median_of_window_samples

`default_nettype wire

// ===== design/mows_cell.sv =====
// One cell of the insertion-sort chain: holds one sorted sample of the batch.
`default_nettype none

module mows_cell (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire logic            occupied,
  input  wire mows_pkg::sample_t sample,
  input  wire mows_pkg::link_t left,
  output mows_pkg::link_t      right,
  output mows_pkg::sample_t    value_nxt
);
  import mows_pkg::*;

  sample_t value_r;
  logic    stay;

  // Occupied cells holding a value not above the new sample keep it.
  assign stay = occupied && (value_r <= sample);

  // Otherwise take the sample if the left neighbor stays, else shift right.
  always_comb begin
    if (stay) begin
      value_nxt = value_r;
    end else if (left.stay) begin
      value_nxt = sample;
    end else begin
      value_nxt = left.value;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value_nxt;
    end
  end

  assign right.stay  = stay;
  assign right.value = value_r;

endmodule : mows_cell

`default_nettype wire
